[sv/rma_pkg.sv]
// shared constants for the rotor multiply and rotate unit
package rma_pkg;

    // default word geometry
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // operation codes carried on the kind port
    localparam logic KIND_ROTATE   = 1'b0;
    localparam logic KIND_MULTIPLY = 1'b1;

endpackage

[sv/rotor_multiply_and_rotate.sv]
// rotor unit: vector rotation by a rotor and rotor product, pipelined
//
// Usage:
//   A command beat is taken at each rising edge where start is high and busy
//   is low. busy is always low, so a new command may be issued every cycle.
//   kind selects the operation: rotate the vector first_x/y/z by the rotor
//   second_s/x/y/z, or multiply rotor first by rotor second.
//   Each result beat appears on out_s/x/y/z and saturated for one cycle,
//   marked by done, once the command has passed all five register stages,
//   and results leave in command order. Throughput is one beat per cycle.
//   The pipeline has five register stages: operand capture, a first
//   bank of sixteen multipliers, sum and clip of the first terms, a second
//   bank of twelve multipliers for the rotation, and the final sum and clip.
//   The receiver cannot stall; done is a plain strobe.
//   Reset clears the valid bits of all stages, so no done pulse follows a
//   reset until new commands arrive; commands in flight are dropped.
//   saturated reports that any clipped sum (the intermediate vector and dot
//   product too, when rotating) hit the word limits.
module rotor_multiply_and_rotate #(
    parameter int WORD_BITS = rma_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = rma_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        kind,
    input  logic signed [WORD_BITS-1:0] first_s,
    input  logic signed [WORD_BITS-1:0] first_x,
    input  logic signed [WORD_BITS-1:0] first_y,
    input  logic signed [WORD_BITS-1:0] first_z,
    input  logic signed [WORD_BITS-1:0] second_s,
    input  logic signed [WORD_BITS-1:0] second_x,
    input  logic signed [WORD_BITS-1:0] second_y,
    input  logic signed [WORD_BITS-1:0] second_z,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] out_s,
    output logic signed [WORD_BITS-1:0] out_x,
    output logic signed [WORD_BITS-1:0] out_y,
    output logic signed [WORD_BITS-1:0] out_z,
    output logic                        saturated
);
    import rma_pkg::*;

    localparam int PW = 2 * WORD_BITS + 2;
    localparam int SW = PW + 2;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [WORD_BITS:0]   opnd_t;
    typedef logic signed [PW-1:0]        prod_t;
    typedef logic signed [SW-1:0]        sum_t;

    // exact product, then arithmetic shift by the fraction width
    function automatic prod_t fmul(word_t a, opnd_t b);
        logic signed [2*WORD_BITS:0] full;
        full = a * b;
        return prod_t'(full >>> FRAC_BITS);
    endfunction

    function automatic opnd_t widen(word_t a);
        return {a[WORD_BITS-1], a};
    endfunction

    // sum leaves the word range
    function automatic logic sat_ovf(sum_t v);
        logic [SW-WORD_BITS:0] top;
        top = v[SW-1:WORD_BITS-1];
        return !((&top) || !(|top));
    endfunction

    // clip to the word range
    function automatic word_t sat_word(sum_t v);
        word_t r;
        if (sat_ovf(v))
        begin
            if (v[SW-1])
                r = {1'b1, {(WORD_BITS-1){1'b0}}};
            else
                r = {1'b0, {(WORD_BITS-1){1'b1}}};
        end
        else
        begin
            r = v[WORD_BITS-1:0];
        end
        return r;
    endfunction

    // stage 0: operand capture
    logic  s0_vld_reg, s0_vld_next;
    logic  s0_kind_reg;
    word_t s0_a_reg [4];
    word_t s0_b_reg [4];

    // stage 1: first multiplier bank
    logic  s1_vld_reg;
    logic  s1_kind_reg;
    prod_t s1_p_reg [16];
    prod_t s1_p_next [16];
    word_t s1_rot_reg [4];
    word_t m_a [16];
    word_t m_b [16];
    word_t as_eff;

    // stage 2: intermediate sums and clip
    logic  s2_vld_reg;
    logic  s2_kind_reg;
    word_t s2_c_reg [4];
    word_t s2_c_next [4];
    logic  s2_flag_reg, s2_flag_next;
    word_t s2_rot_reg [4];
    sum_t  sum2 [4];
    sum_t  dot2;

    // stage 3: second multiplier bank
    logic  s3_vld_reg;
    logic  s3_kind_reg;
    prod_t s3_q_reg [12];
    prod_t s3_q_next [12];
    word_t s3_c_reg [4];
    logic  s3_flag_reg;
    word_t vt [4];
    opnd_t bs3, bx3, by3, bz3, ntz3;

    // stage 4: final sums, clip and output register
    logic  s4_vld_reg;
    logic  s4_kind_reg;
    word_t s4_out_reg [4];
    word_t s4_out_next [4];
    logic  s4_flag_reg, s4_flag_next;
    sum_t  sum4 [3];

    assign busy        = 1'b0;
    assign s0_vld_next = start && !busy;

    // first bank operands: scalar of the first rotor is zero when rotating
    always_comb
    begin
        as_eff = (s0_kind_reg == KIND_MULTIPLY) ? s0_a_reg[0] : '0;
        // scalar / dot row
        m_a[0]  = as_eff;      m_b[0]  = s0_b_reg[0];
        m_a[1]  = s0_a_reg[1]; m_b[1]  = s0_b_reg[1];
        m_a[2]  = s0_a_reg[2]; m_b[2]  = s0_b_reg[2];
        m_a[3]  = s0_a_reg[3]; m_b[3]  = s0_b_reg[3];
        // x row
        m_a[4]  = as_eff;      m_b[4]  = s0_b_reg[1];
        m_a[5]  = s0_b_reg[0]; m_b[5]  = s0_a_reg[1];
        m_a[6]  = s0_a_reg[2]; m_b[6]  = s0_b_reg[3];
        m_a[7]  = s0_a_reg[3]; m_b[7]  = s0_b_reg[2];
        // y row
        m_a[8]  = as_eff;      m_b[8]  = s0_b_reg[2];
        m_a[9]  = s0_b_reg[0]; m_b[9]  = s0_a_reg[2];
        m_a[10] = s0_a_reg[3]; m_b[10] = s0_b_reg[1];
        m_a[11] = s0_a_reg[1]; m_b[11] = s0_b_reg[3];
        // z row
        m_a[12] = as_eff;      m_b[12] = s0_b_reg[3];
        m_a[13] = s0_b_reg[0]; m_b[13] = s0_a_reg[3];
        m_a[14] = s0_a_reg[1]; m_b[14] = s0_b_reg[2];
        m_a[15] = s0_a_reg[2]; m_b[15] = s0_b_reg[1];
        for (int i = 0; i < 16; i++)
        begin
            s1_p_next[i] = fmul(m_a[i], widen(m_b[i]));
        end
    end

    // first sums: rotor product, or intermediate vector and dot product
    always_comb
    begin
        dot2 = sum_t'(s1_p_reg[1]) + sum_t'(s1_p_reg[2]) + sum_t'(s1_p_reg[3]);
        if (s1_kind_reg == KIND_MULTIPLY)
            sum2[0] = sum_t'(s1_p_reg[0]) - dot2;
        else
            sum2[0] = dot2;
        for (int r = 1; r < 4; r++)
        begin
            sum2[r] = sum_t'(s1_p_reg[4*r]) + sum_t'(s1_p_reg[4*r+1])
                    + sum_t'(s1_p_reg[4*r+2]) - sum_t'(s1_p_reg[4*r+3]);
        end
        s2_flag_next = 1'b0;
        for (int r = 0; r < 4; r++)
        begin
            s2_c_next[r] = sat_word(sum2[r]);
            s2_flag_next = s2_flag_next | sat_ovf(sum2[r]);
        end
    end

    // second bank: intermediate vector and dot product against the rotor
    always_comb
    begin
        vt[0] = s2_c_reg[1];
        vt[1] = s2_c_reg[2];
        vt[2] = s2_c_reg[3];
        vt[3] = s2_c_reg[0];
        bs3   = widen(s2_rot_reg[0]);
        bx3   = widen(s2_rot_reg[1]);
        by3   = widen(s2_rot_reg[2]);
        bz3   = widen(s2_rot_reg[3]);
        ntz3  = -bz3;
        // x row
        s3_q_next[0]  = fmul(vt[0], bs3);
        s3_q_next[1]  = fmul(vt[1], bz3);
        s3_q_next[2]  = fmul(vt[2], by3);
        s3_q_next[3]  = fmul(vt[3], bx3);
        // y row, negated z taken before the product
        s3_q_next[4]  = fmul(vt[0], ntz3);
        s3_q_next[5]  = fmul(vt[1], bs3);
        s3_q_next[6]  = fmul(vt[2], bx3);
        s3_q_next[7]  = fmul(vt[3], by3);
        // z row
        s3_q_next[8]  = fmul(vt[0], by3);
        s3_q_next[9]  = fmul(vt[1], bx3);
        s3_q_next[10] = fmul(vt[2], bs3);
        s3_q_next[11] = fmul(vt[3], bz3);
    end

    // final sums; rotor products pass straight through
    always_comb
    begin
        sum4[0] = sum_t'(s3_q_reg[0]) + sum_t'(s3_q_reg[1])
                - sum_t'(s3_q_reg[2]) + sum_t'(s3_q_reg[3]);
        sum4[1] = sum_t'(s3_q_reg[4]) + sum_t'(s3_q_reg[5])
                + sum_t'(s3_q_reg[6]) + sum_t'(s3_q_reg[7]);
        sum4[2] = sum_t'(s3_q_reg[8]) - sum_t'(s3_q_reg[9])
                + sum_t'(s3_q_reg[10]) + sum_t'(s3_q_reg[11]);
        if (s3_kind_reg == KIND_MULTIPLY)
        begin
            for (int r = 0; r < 4; r++)
            begin
                s4_out_next[r] = s3_c_reg[r];
            end
            s4_flag_next = s3_flag_reg;
        end
        else
        begin
            s4_out_next[0] = '0;
            s4_flag_next   = s3_flag_reg;
            for (int r = 0; r < 3; r++)
            begin
                s4_out_next[r+1] = sat_word(sum4[r]);
                s4_flag_next     = s4_flag_next | sat_ovf(sum4[r]);
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= s0_vld_next;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    // payload registers, loaded behind their valid bit
    always_ff @(posedge clk)
    begin
        if (s0_vld_next)
        begin
            s0_kind_reg <= kind;
            s0_a_reg[0] <= first_s;
            s0_a_reg[1] <= first_x;
            s0_a_reg[2] <= first_y;
            s0_a_reg[3] <= first_z;
            s0_b_reg[0] <= second_s;
            s0_b_reg[1] <= second_x;
            s0_b_reg[2] <= second_y;
            s0_b_reg[3] <= second_z;
        end
        if (s0_vld_reg)
        begin
            s1_kind_reg <= s0_kind_reg;
            s1_p_reg    <= s1_p_next;
            s1_rot_reg  <= s0_b_reg;
        end
        if (s1_vld_reg)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_c_reg    <= s2_c_next;
            s2_flag_reg <= s2_flag_next;
            s2_rot_reg  <= s1_rot_reg;
        end
        if (s2_vld_reg)
        begin
            s3_kind_reg <= s2_kind_reg;
            s3_q_reg    <= s3_q_next;
            s3_c_reg    <= s2_c_reg;
            s3_flag_reg <= s2_flag_reg;
        end
        if (s3_vld_reg)
        begin
            s4_kind_reg <= s3_kind_reg;
            s4_out_reg  <= s4_out_next;
            s4_flag_reg <= s4_flag_next;
        end
    end

    // result beat
    assign done      = s4_vld_reg;
    assign out_s     = s4_out_reg[0];
    assign out_x     = s4_out_reg[1];
    assign out_y     = s4_out_reg[2];
    assign out_z     = s4_out_reg[3];
    assign saturated = s4_flag_reg;

    // every command beat yields a result beat after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("result beat missing after command");

    // no result beat without a matching earlier command
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##5 !done)
        else $error("result beat without command");

    // rotation results carry a zero scalar
    a_rot_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        (done && s4_kind_reg == KIND_ROTATE) |-> (out_s == '0))
        else $error("nonzero scalar on rotation result");

endmodule
